FILE: hw/rtl/adsr_pkg.sv
// ============================================================================
// adsr_pkg
// Shared types and constants for the envelope channel bank: transaction
// layouts, per-channel state records, opcodes and phase codes.
// ============================================================================
`default_nettype none

package adsr_pkg;

    // number of channels in the bank
    localparam int CHANNELS = 12;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 8;
    localparam int MUL_B_W = 9;
    localparam int MUL_P_W = 16;

    // opcodes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_KEY_ON  = 2'd1;
    localparam logic [1:0] OP_KEY_OFF = 2'd2;
    localparam logic [1:0] OP_KILL    = 2'd3;

    // envelope phase codes
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_PENDING = 3'd1;
    localparam logic [2:0] PH_ATTACK  = 3'd2;
    localparam logic [2:0] PH_DECAY   = 3'd3;
    localparam logic [2:0] PH_SUSTAIN = 3'd4;

    localparam logic [7:0] LEVEL_MAX = 8'hFF;

    // input transaction
    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] channel;
        logic [7:0] attack_rate;
        logic [7:0] decay_rate;
        logic [7:0] sustain_level;
        logic [7:0] release_rate;
        logic [7:0] echo_level;
        logic [7:0] echo_frames;
        logic [7:0] pan_right;
        logic [7:0] pan_left;
    } adsr_in_t;

    // result transaction
    typedef struct packed {
        logic [3:0] channel_out;
        logic [2:0] phase;
        logic       releasing;
        logic       in_echo;
        logic [7:0] level;
        logic [7:0] right_level;
        logic [7:0] left_level;
    } adsr_out_t;

    // per-channel control state, cleared by reset
    typedef struct packed {
        logic [2:0] phase;
        logic       releasing;
        logic       in_echo;
        logic [7:0] level;
        logic [7:0] out_r;
        logic [7:0] out_l;
    } chan_state_t;

    // per-channel note settings, loaded on key on
    typedef struct packed {
        logic [7:0] atk;
        logic [7:0] dec;
        logic [7:0] sus;
        logic [7:0] rel;
        logic [7:0] echo_lvl;
        logic [7:0] echo_cnt;
        logic [7:0] pan_r;
        logic [7:0] pan_l;
    } chan_param_t;

    // write controls into the channel store
    typedef struct packed {
        logic            state_we;
        logic            param_we;
        logic            cnt_we;
        logic [CH_W-1:0] idx;
    } chan_wr_t;

endpackage

`default_nettype wire

FILE: hw/rtl/adsr_envelope_channel_bank.sv
// ============================================================================
// adsr_envelope_channel_bank
// Bank of envelope channels. A small sequencer steps the addressed channel
// through attack, decay, sustain, release and echo tail, then scales the
// level by master volume and pan using one shared multiplier.
// ============================================================================
//
//   port group     direction   handshake          content
//   cmd            in          cmd_valid/stall    opcode, channel, note settings
//   res            out         res_valid/stall    phase, flags, level, pan levels
//   cfg_wr         in          cfg_wr_en          master volume (4 bits)
//
// One transaction at a time. Key on, key off, kill, idle ticks and ticks that
// end a note without a multiply go from evaluation straight to write-back; a
// decay or release tick that ends the note passes through the envelope step
// first; a tick that scales the level makes its passes through the shared
// multiplier (envelope step with a decay or release multiply, then master
// volume, right pan, left pan).
// cmd_stall is high from accept until the result transaction completes.
// Reset clears every channel to idle with zero level and outputs, and sets
// master volume to 15; no clearing pass is needed.
`default_nettype none

module adsr_envelope_channel_bank (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire adsr_pkg::adsr_in_t cmd,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output adsr_pkg::adsr_out_t     res,
    input  wire logic               cfg_wr_en,
    input  wire logic [3:0]         cfg_wr_data
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_EVAL  = 9'b000000010,
        S_ENV   = 9'b000000100,
        S_SCALE = 9'b000001000,
        S_PANR  = 9'b000010000,
        S_PANL  = 9'b000100000,
        S_OUTL  = 9'b001000000,
        S_WB    = 9'b010000000,
        S_DONE  = 9'b100000000
    } seq_state_t;

    localparam logic [4:0] CH_LIMIT = 5'(adsr_pkg::CHANNELS);
    localparam logic [adsr_pkg::MUL_B_W-1:0] MUL_B_ONE = adsr_pkg::MUL_B_W'(1);

    seq_state_t            state_reg, state_next;
    adsr_pkg::adsr_in_t    item_reg, item_next;
    adsr_pkg::chan_state_t wk_reg, wk_next;
    adsr_pkg::adsr_out_t   res_reg, res_next;
    logic [7:0]            s_reg, s_next;
    logic [3:0]            mv_reg;

    adsr_pkg::chan_wr_t    wr;
    adsr_pkg::chan_state_t cur;
    adsr_pkg::chan_param_t par;
    adsr_pkg::chan_param_t par_wdata;
    logic [7:0]            cnt_wdata;

    logic [adsr_pkg::MUL_A_W-1:0] mul_a;
    logic [adsr_pkg::MUL_B_W-1:0] mul_b;
    logic [adsr_pkg::MUL_P_W-1:0] prod;

    logic       ch_ok;
    logic [8:0] atk_sum;
    logic [7:0] atk_base;
    logic [7:0] env_p;
    logic       start_echo;

    // channel store and shared multiplier
    adsr_chan_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr          (wr),
        .state_wdata (wk_reg),
        .param_wdata (par_wdata),
        .cnt_wdata   (cnt_wdata),
        .state_rd    (cur),
        .param_rd    (par)
    );

    adsr_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // master volume register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_reg <= 4'hF;
        end
        else if (cfg_wr_en)
        begin
            mv_reg <= cfg_wr_data;
        end
    end

    // sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        wk_reg   <= wk_next;
        res_reg  <= res_next;
        s_reg    <= s_next;
    end

    // addressed channel and settings from a key on transaction
    assign ch_ok = {1'b0, item_reg.channel} < CH_LIMIT;

    always_comb
    begin
        par_wdata.atk      = item_reg.attack_rate;
        par_wdata.dec      = item_reg.decay_rate;
        par_wdata.sus      = item_reg.sustain_level;
        par_wdata.rel      = item_reg.release_rate;
        par_wdata.echo_lvl = item_reg.echo_level;
        par_wdata.echo_cnt = item_reg.echo_frames;
        par_wdata.pan_r    = item_reg.pan_right;
        par_wdata.pan_l    = item_reg.pan_left;
    end

    // echo tail countdown
    assign cnt_wdata = par.echo_cnt - 8'd1;

    // attack step, from zero when the note is still pending
    assign atk_base = (cur.phase == adsr_pkg::PH_PENDING) ? 8'd0 : cur.level;
    assign atk_sum  = {1'b0, atk_base} + {1'b0, par.atk};

    // envelope after the decay or release multiply
    assign env_p = prod[15:8];

    always_comb
    begin
        if (wk_reg.releasing)
        begin
            start_echo = env_p <= par.echo_lvl;
        end
        else
        begin
            start_echo = (env_p <= par.sus) && (par.sus == 8'd0);
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        item_next    = item_reg;
        wk_next      = wk_reg;
        res_next     = res_reg;
        s_next       = s_reg;
        wr           = '0;
        wr.idx       = item_reg.channel[adsr_pkg::CH_W-1:0];
        mul_a        = wk_reg.level;
        mul_b        = {1'b0, par.rel};

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next  = cmd;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                wk_next    = cur;
                state_next = S_WB;
                mul_a      = cur.level;
                if (ch_ok)
                begin
                    case (item_reg.opcode)
                        adsr_pkg::OP_KEY_ON:
                        begin
                            wr.param_we       = 1'b1;
                            wk_next.phase     = adsr_pkg::PH_PENDING;
                            wk_next.releasing = 1'b0;
                            wk_next.in_echo   = 1'b0;
                        end
                        adsr_pkg::OP_KEY_OFF:
                        begin
                            if (cur.phase != adsr_pkg::PH_IDLE)
                            begin
                                wk_next.releasing = 1'b1;
                            end
                        end
                        adsr_pkg::OP_KILL:
                        begin
                            wk_next.phase     = adsr_pkg::PH_IDLE;
                            wk_next.releasing = 1'b0;
                            wk_next.in_echo   = 1'b0;
                        end
                        default:
                        begin
                            // frame tick
                            if (cur.phase == adsr_pkg::PH_IDLE)
                            begin
                                state_next = S_WB;
                            end
                            else if ((cur.phase == adsr_pkg::PH_PENDING) && cur.releasing)
                            begin
                                wk_next.phase     = adsr_pkg::PH_IDLE;
                                wk_next.releasing = 1'b0;
                                wk_next.in_echo   = 1'b0;
                            end
                            else if (cur.phase == adsr_pkg::PH_PENDING ||
                                     (!cur.in_echo && !cur.releasing &&
                                      cur.phase == adsr_pkg::PH_ATTACK))
                            begin
                                if (atk_sum >= {1'b0, adsr_pkg::LEVEL_MAX})
                                begin
                                    wk_next.level = adsr_pkg::LEVEL_MAX;
                                    wk_next.phase = adsr_pkg::PH_DECAY;
                                end
                                else
                                begin
                                    wk_next.level = atk_sum[7:0];
                                    wk_next.phase = adsr_pkg::PH_ATTACK;
                                end
                                state_next = S_SCALE;
                            end
                            else if (cur.in_echo)
                            begin
                                wr.cnt_we = 1'b1;
                                if (cnt_wdata == 8'd0)
                                begin
                                    wk_next.phase     = adsr_pkg::PH_IDLE;
                                    wk_next.releasing = 1'b0;
                                    wk_next.in_echo   = 1'b0;
                                end
                                else
                                begin
                                    state_next = S_SCALE;
                                end
                            end
                            else if (cur.releasing)
                            begin
                                mul_b      = {1'b0, par.rel};
                                state_next = S_ENV;
                            end
                            else if (cur.phase == adsr_pkg::PH_DECAY)
                            begin
                                mul_b      = {1'b0, par.dec};
                                state_next = S_ENV;
                            end
                            else
                            begin
                                // sustain holds the level
                                state_next = S_SCALE;
                            end
                        end
                    endcase
                end
            end

            S_ENV:
            begin
                state_next = S_SCALE;
                if (start_echo)
                begin
                    if (par.echo_lvl == 8'd0)
                    begin
                        wk_next.phase     = adsr_pkg::PH_IDLE;
                        wk_next.releasing = 1'b0;
                        wk_next.in_echo   = 1'b0;
                        state_next        = S_WB;
                    end
                    else
                    begin
                        wk_next.level   = par.echo_lvl;
                        wk_next.in_echo = 1'b1;
                    end
                end
                else if (!wk_reg.releasing && env_p <= par.sus)
                begin
                    wk_next.level = par.sus;
                    wk_next.phase = adsr_pkg::PH_SUSTAIN;
                end
                else
                begin
                    wk_next.level = env_p;
                end
            end

            S_SCALE:
            begin
                mul_a      = wk_reg.level;
                mul_b      = MUL_B_ONE + {5'd0, mv_reg};
                state_next = S_PANR;
            end

            S_PANR:
            begin
                s_next     = prod[11:4];
                mul_a      = par.pan_r;
                mul_b      = {1'b0, prod[11:4]};
                state_next = S_PANL;
            end

            S_PANL:
            begin
                wk_next.out_r = prod[15:8];
                mul_a         = par.pan_l;
                mul_b         = {1'b0, s_reg};
                state_next    = S_OUTL;
            end

            S_OUTL:
            begin
                wk_next.out_l = prod[15:8];
                state_next    = S_WB;
            end

            S_WB:
            begin
                res_next             = '0;
                res_next.channel_out = item_reg.channel;
                if (ch_ok)
                begin
                    wr.state_we          = 1'b1;
                    res_next.phase       = wk_reg.phase;
                    res_next.releasing   = wk_reg.releasing;
                    res_next.in_echo     = wk_reg.in_echo;
                    res_next.level       = wk_reg.level;
                    res_next.right_level = wk_reg.out_r;
                    res_next.left_level  = wk_reg.out_l;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!res_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // handshake outputs
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    // an accepted transaction blocks the command side on the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall) |=> cmd_stall)
        else $error("command accepted while a transaction is in progress");

    // a result is never offered while the command side is open
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cmd_stall)
        else $error("result and command side open together");

    // an idle channel carries no release or echo flag
    a_idle_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.phase == adsr_pkg::PH_IDLE) |-> (!res.releasing && !res.in_echo))
        else $error("idle channel reported with a flag set");

    // an echo tail always plays at a non-zero level
    a_echo_level: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.in_echo) |-> (res.level != 8'd0))
        else $error("echo tail at zero level");

endmodule

`default_nettype wire

FILE: hw/rtl/adsr_mul.sv
// ============================================================================
// adsr_mul
// Shared unsigned multiplier with a registered product, reused for the
// envelope scaling, master volume and both pan products.
// ============================================================================
`default_nettype none

module adsr_mul (
    input  wire logic                          clk,
    input  wire logic [adsr_pkg::MUL_A_W-1:0]  a,
    input  wire logic [adsr_pkg::MUL_B_W-1:0]  b,
    output logic      [adsr_pkg::MUL_P_W-1:0]  prod
);

    localparam int FULL_W = adsr_pkg::MUL_A_W + adsr_pkg::MUL_B_W;

    logic [FULL_W-1:0]           full;
    logic [adsr_pkg::MUL_P_W-1:0] prod_reg;

    // operands never exceed 255 x 256, so the product fits the result width
    assign full = FULL_W'(a) * FULL_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= full[adsr_pkg::MUL_P_W-1:0];
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/adsr_chan_regs.sv
// ============================================================================
// adsr_chan_regs
// Per-channel storage: control state with reset, note settings without
// reset (only read once a key on has loaded them).
// ============================================================================
`default_nettype none

module adsr_chan_regs (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire adsr_pkg::chan_wr_t    wr,
    input  wire adsr_pkg::chan_state_t state_wdata,
    input  wire adsr_pkg::chan_param_t param_wdata,
    input  wire logic [7:0]            cnt_wdata,
    output adsr_pkg::chan_state_t      state_rd,
    output adsr_pkg::chan_param_t      param_rd
);

    adsr_pkg::chan_state_t state_reg [adsr_pkg::CHANNELS];
    adsr_pkg::chan_param_t param_reg [adsr_pkg::CHANNELS];

    // control state, all channels idle after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < adsr_pkg::CHANNELS; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else if (wr.state_we)
        begin
            state_reg[wr.idx] <= state_wdata;
        end
    end

    // note settings and echo tail counter
    always_ff @(posedge clk)
    begin
        if (wr.param_we)
        begin
            param_reg[wr.idx] <= param_wdata;
        end
        else if (wr.cnt_we)
        begin
            param_reg[wr.idx].echo_cnt <= cnt_wdata;
        end
    end

    // one read port at the addressed channel
    assign state_rd = state_reg[wr.idx];
    assign param_rd = param_reg[wr.idx];

endmodule

`default_nettype wire

FILE: tb/sv/adsr_envelope_channel_bank_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// adsr_envelope_channel_bank_checker
// Watches the command, result and master volume ports of the envelope bank.
// Keeps its own copy of every channel's envelope, predicts the result of
// each accepted command and checks results field by field, in order.
// ============================================================================

module adsr_envelope_channel_bank_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  logic                 cmd_stall,
    input  adsr_pkg::adsr_in_t   cmd,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  adsr_pkg::adsr_out_t  res,
    input  logic                 cfg_wr_en,
    input  logic [3:0]           cfg_wr_data,
    output int                   mismatch_count,
    output int                   results_awaited
);

    // shadow copy of the channel bank
    logic [2:0]            env_phase     [adsr_pkg::CHANNELS];
    logic                  env_releasing [adsr_pkg::CHANNELS];
    logic                  env_echo      [adsr_pkg::CHANNELS];
    logic [7:0]            env_level     [adsr_pkg::CHANNELS];
    logic [7:0]            out_right     [adsr_pkg::CHANNELS];
    logic [7:0]            out_left      [adsr_pkg::CHANNELS];
    adsr_pkg::chan_param_t note_set      [adsr_pkg::CHANNELS];
    logic [3:0]            master_vol;

    adsr_pkg::adsr_out_t   awaited_results[$];
    adsr_pkg::adsr_out_t   want;

    // envelope update for one command, returns the result it should produce
    function automatic adsr_pkg::adsr_out_t next_envelope_result(adsr_pkg::adsr_in_t item);
        adsr_pkg::adsr_out_t result;
        int unsigned c;
        int unsigned lvl;
        int unsigned scaled;
        logic [2:0]  nph;
        bit          start_echo;
        bit          silence;

        result = '0;
        result.channel_out = item.channel;
        c = item.channel;
        // channels beyond the bank give an empty result
        if (c >= adsr_pkg::CHANNELS)
            return result;

        case (item.opcode)
            adsr_pkg::OP_TICK:
            begin
                if (env_phase[c] != adsr_pkg::PH_IDLE)
                begin
                    lvl        = env_level[c];
                    nph        = env_phase[c];
                    start_echo = 1'b0;
                    silence    = 1'b0;
                    if (env_phase[c] == adsr_pkg::PH_PENDING)
                    begin
                        // key off before the first tick drops the note
                        if (env_releasing[c])
                            silence = 1'b1;
                        else
                        begin
                            lvl = note_set[c].atk;
                            nph = adsr_pkg::PH_ATTACK;
                            if (lvl >= adsr_pkg::LEVEL_MAX)
                            begin
                                lvl = adsr_pkg::LEVEL_MAX;
                                nph = adsr_pkg::PH_DECAY;
                            end
                        end
                    end
                    else if (env_echo[c])
                    begin
                        // tail counter wraps, so a length of zero runs 256 ticks
                        note_set[c].echo_cnt = note_set[c].echo_cnt - 8'd1;
                        if (note_set[c].echo_cnt == 8'd0)
                            silence = 1'b1;
                    end
                    else if (env_releasing[c])
                    begin
                        lvl = (lvl * note_set[c].rel) >> 8;
                        if (lvl <= note_set[c].echo_lvl)
                            start_echo = 1'b1;
                    end
                    else if (env_phase[c] == adsr_pkg::PH_ATTACK)
                    begin
                        lvl = lvl + note_set[c].atk;
                        if (lvl >= adsr_pkg::LEVEL_MAX)
                        begin
                            lvl = adsr_pkg::LEVEL_MAX;
                            nph = adsr_pkg::PH_DECAY;
                        end
                    end
                    else if (env_phase[c] == adsr_pkg::PH_DECAY)
                    begin
                        lvl = (lvl * note_set[c].dec) >> 8;
                        if (lvl <= note_set[c].sus)
                        begin
                            lvl = note_set[c].sus;
                            if (lvl == 0)
                                start_echo = 1'b1;
                            else
                                nph = adsr_pkg::PH_SUSTAIN;
                        end
                    end

                    // echo tail takes over at the echo volume, none when zero
                    if (start_echo)
                    begin
                        lvl = note_set[c].echo_lvl;
                        if (lvl == 0)
                            silence = 1'b1;
                        else
                            env_echo[c] = 1'b1;
                    end

                    if (silence)
                    begin
                        env_phase[c]     = adsr_pkg::PH_IDLE;
                        env_releasing[c] = 1'b0;
                        env_echo[c]      = 1'b0;
                    end
                    else
                    begin
                        env_phase[c] = nph;
                        env_level[c] = 8'(lvl);
                        scaled       = (lvl * (master_vol + 1)) >> 4;
                        out_right[c] = 8'((note_set[c].pan_r * scaled) >> 8);
                        out_left[c]  = 8'((note_set[c].pan_l * scaled) >> 8);
                    end
                end
            end
            adsr_pkg::OP_KEY_ON:
            begin
                note_set[c] = {item.attack_rate, item.decay_rate, item.sustain_level,
                               item.release_rate, item.echo_level, item.echo_frames,
                               item.pan_right, item.pan_left};
                env_phase[c]     = adsr_pkg::PH_PENDING;
                env_releasing[c] = 1'b0;
                env_echo[c]      = 1'b0;
            end
            adsr_pkg::OP_KEY_OFF:
            begin
                if (env_phase[c] != adsr_pkg::PH_IDLE)
                    env_releasing[c] = 1'b1;
            end
            adsr_pkg::OP_KILL:
            begin
                env_phase[c]     = adsr_pkg::PH_IDLE;
                env_releasing[c] = 1'b0;
                env_echo[c]      = 1'b0;
            end
            default:
            begin
            end
        endcase

        result.phase       = env_phase[c];
        result.releasing   = env_releasing[c];
        result.in_echo     = env_echo[c];
        result.level       = env_level[c];
        result.right_level = out_right[c];
        result.left_level  = out_left[c];
        return result;
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("%s on channel %0d: got %0d, expected %0d",
                                      name, want.channel_out, got, exp_val));
    endtask

    // predict on each command transaction, compare on each result transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < adsr_pkg::CHANNELS; i++)
            begin
                env_phase[i]     = adsr_pkg::PH_IDLE;
                env_releasing[i] = 1'b0;
                env_echo[i]      = 1'b0;
                env_level[i]     = '0;
                out_right[i]     = '0;
                out_left[i]      = '0;
                note_set[i]      = '0;
            end
            master_vol = 4'd15;
            awaited_results.delete();
            mismatch_count  = 0;
            results_awaited = 0;
        end
        else
        begin
            if (cfg_wr_en)
                master_vol = cfg_wr_data;
            if (cmd_valid && !cmd_stall)
                awaited_results.push_back(next_envelope_result(cmd));
            if (res_valid && !res_stall)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("result for channel %0d with none awaited",
                                              res.channel_out));
                else
                begin
                    want = awaited_results.pop_front();
                    check_field("channel_out", res.channel_out, want.channel_out);
                    check_field("phase", res.phase, want.phase);
                    check_field("releasing", res.releasing, want.releasing);
                    check_field("in_echo", res.in_echo, want.in_echo);
                    check_field("level", res.level, want.level);
                    check_field("right_level", res.right_level, want.right_level);
                    check_field("left_level", res.left_level, want.left_level);
                end
            end
            results_awaited = awaited_results.size();
        end
    end

endmodule

FILE: tb/sv/adsr_envelope_channel_bank_test.sv
`timescale 1ns / 1ps
// ============================================================================
// adsr_envelope_channel_bank_test
// Drives the envelope bank with a short directed run through idle ticks,
// full attack-decay-echo and sustain-release notes, kills and out-of-range
// channels, then random note sequences with noise under several master
// volumes, random idling on both sides and a long result back-pressure.
// ============================================================================

module adsr_envelope_channel_bank_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_PCT    = 17;

    logic                clk;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_stall;
    adsr_pkg::adsr_in_t  cmd;
    logic                res_valid;
    logic                res_stall;
    adsr_pkg::adsr_out_t res;
    logic                cfg_wr_en;
    logic [3:0]          cfg_wr_data;

    int          mismatch_count;
    int          results_awaited;
    int unsigned commands_sent;
    int unsigned cycle_count;
    bit          calm;
    bit          hold_req;

    adsr_envelope_channel_bank u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    adsr_envelope_channel_bank_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd             (cmd),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .mismatch_count  (mismatch_count),
        .results_awaited (results_awaited)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // run limit
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // result side: random stall, or one long hold-off when asked
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                res_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // command with a given opcode and channel, random payload
    function automatic adsr_pkg::adsr_in_t bare_cmd(input logic [1:0] op, input int ch);
        adsr_pkg::adsr_in_t item;
        item.opcode  = op;
        item.channel = 4'(ch);
        {item.attack_rate, item.decay_rate, item.sustain_level, item.release_rate}
            = $urandom;
        {item.echo_level, item.echo_frames, item.pan_right, item.pan_left} = $urandom;
        return item;
    endfunction

    function automatic adsr_pkg::adsr_in_t key_on_cmd(input int ch,
                                            input logic [7:0] atk, dec, sus, rel,
                                            input logic [7:0] echo_lvl, echo_len,
                                            input logic [7:0] pan_r, pan_l);
        adsr_pkg::adsr_in_t item;
        item = '{adsr_pkg::OP_KEY_ON, 4'(ch), atk, dec, sus, rel, echo_lvl, echo_len,
                 pan_r, pan_l};
        return item;
    endfunction

    // one command transaction, with random idle cycles before it
    task automatic send_cmd(input adsr_pkg::adsr_in_t item);
        @(negedge clk);
        while (!calm && ($urandom_range(99) < IDLE_PCT))
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd       <= item;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        commands_sent++;
    endtask

    // stop offering and wait for every awaited result
    task automatic drain_results();
        @(negedge clk);
        cmd_valid <= 1'b0;
        while (results_awaited != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_master_volume(input logic [3:0] vol);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= vol;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // ticks on one channel with the odd stray command mixed in
    task automatic tick_channel(input int ch, input int count);
        repeat (count)
        begin
            if ($urandom_range(99) < 15)
                send_cmd(bare_cmd(2'($urandom_range(3)), $urandom_range(15)));
            else
                send_cmd(bare_cmd(adsr_pkg::OP_TICK, ch));
        end
    endtask

    // random note sequences: key on, ticks, key off or kill, more ticks
    task automatic run_random_phase(input int unsigned count);
        int unsigned        stop_at;
        int                 ch;
        adsr_pkg::adsr_in_t item;
        stop_at = commands_sent + count;
        while (commands_sent < stop_at)
        begin
            if ($urandom_range(99) < 20)
                send_cmd(bare_cmd(2'($urandom_range(3)), $urandom_range(15)));
            else
            begin
                ch   = $urandom_range(adsr_pkg::CHANNELS - 1);
                item = bare_cmd(adsr_pkg::OP_KEY_ON, ch);
                case ($urandom_range(3))
                    0: item.attack_rate = 8'hFF;
                    1: item.attack_rate = 8'($urandom_range(128, 254));
                    2: item.attack_rate = 8'($urandom_range(1, 127));
                    default: ;
                endcase
                if ($urandom_range(3) == 0)
                    item.sustain_level = 8'h00;
                if ($urandom_range(3) == 0)
                    item.echo_level = 8'h00;
                // mostly short tails so notes run out
                case ($urandom_range(9))
                    0: item.echo_frames = 8'h00;
                    1, 2: ;
                    default: item.echo_frames = 8'($urandom_range(1, 6));
                endcase
                send_cmd(item);
                tick_channel(ch, $urandom_range(1, 10));
                case ($urandom_range(9))
                    0: send_cmd(bare_cmd(adsr_pkg::OP_KILL, ch));
                    1, 2: ;
                    default: send_cmd(bare_cmd(adsr_pkg::OP_KEY_OFF, ch));
                endcase
                tick_channel(ch, $urandom_range(1, 12));
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        commands_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_master_volume(4'd7);

        // idle channel: tick and key off do nothing
        send_cmd(bare_cmd(adsr_pkg::OP_TICK, 0));
        send_cmd(bare_cmd(adsr_pkg::OP_KEY_OFF, 0));
        // full attack, instant decay to zero sustain, echo tail of two ticks
        send_cmd(key_on_cmd(0, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hC8, 8'd2, 8'hFF, 8'hFF));
        repeat (5) send_cmd(bare_cmd(adsr_pkg::OP_TICK, 0));
        // stepped attack into sustain, release to zero with no echo
        send_cmd(key_on_cmd(adsr_pkg::CHANNELS - 1, 8'd100, 8'hFF, 8'hFF, 8'h00, 8'h00,
                            8'h00, 8'h00, 8'hFF));
        repeat (5) send_cmd(bare_cmd(adsr_pkg::OP_TICK, adsr_pkg::CHANNELS - 1));
        send_cmd(bare_cmd(adsr_pkg::OP_KEY_OFF, adsr_pkg::CHANNELS - 1));
        send_cmd(bare_cmd(adsr_pkg::OP_TICK, adsr_pkg::CHANNELS - 1));
        // key off while still pending
        send_cmd(bare_cmd(adsr_pkg::OP_KEY_ON, 5));
        send_cmd(bare_cmd(adsr_pkg::OP_KEY_OFF, 5));
        send_cmd(bare_cmd(adsr_pkg::OP_TICK, 5));
        // kill mid-note holds level and outputs
        send_cmd(key_on_cmd(3, 8'd60, 8'd200, 8'd40, 8'd128, 8'd20, 8'd3, 8'h80, 8'h01));
        send_cmd(bare_cmd(adsr_pkg::OP_TICK, 3));
        send_cmd(bare_cmd(adsr_pkg::OP_KILL, 3));
        send_cmd(bare_cmd(adsr_pkg::OP_TICK, 3));
        // channels beyond the bank
        send_cmd(bare_cmd(adsr_pkg::OP_TICK, 15));
        send_cmd(bare_cmd(adsr_pkg::OP_KEY_ON, adsr_pkg::CHANNELS));
        drain_results();

        write_master_volume(4'd0);
        run_random_phase(360);
        drain_results();

        // no idling on either side
        write_master_volume(4'd15);
        calm = 1'b1;
        run_random_phase(360);
        drain_results();
        calm = 1'b0;

        // long back-pressure, then a pause until everything is back
        write_master_volume(4'($urandom_range(15)));
        hold_req = 1'b1;
        run_random_phase(180);
        drain_results();
        run_random_phase(180);
        drain_results();

        write_master_volume(4'($urandom_range(1, 14)));
        run_random_phase(360);
        drain_results();

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: adsr_envelope_channel_bank.f
hw/rtl/adsr_pkg.sv
hw/rtl/adsr_mul.sv
hw/rtl/adsr_chan_regs.sv
hw/rtl/adsr_envelope_channel_bank.sv
tb/sv/adsr_envelope_channel_bank_checker.sv
tb/sv/adsr_envelope_channel_bank_test.sv
